@@ rtl/lnff_pkg.sv @@
// lnff_pkg: shared types, register codes and reset values of the node framer filter
package lnff_pkg;

    localparam int NODE_BYTES = 5;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int ANGLE_DEG_LIMIT = 360;

    typedef enum logic [1:0] {
        REG_DECIMATE_INTERVAL = 2'd0,
        REG_MIN_DISTANCE_MM   = 2'd1,
        REG_MAX_DISTANCE_MM   = 2'd2,
        REG_MIN_QUALITY       = 2'd3
    } t_reg_idx;

    localparam logic [7:0]  RST_DECIMATE_INTERVAL = 8'd20;
    localparam logic [13:0] RST_MIN_DISTANCE_MM   = 14'd100;
    localparam logic [13:0] RST_MAX_DISTANCE_MM   = 14'd6000;
    localparam logic [5:0]  RST_MIN_QUALITY       = 6'd10;

    typedef struct packed {
        logic [7:0]  decimate_interval;
        logic [13:0] min_distance_mm;
        logic [13:0] max_distance_mm;
        logic [5:0]  min_quality;
    } t_cfg;

    typedef struct packed {
        logic [31:0] sample_index;
        logic [14:0] angle_x64;
        logic [15:0] range_x4;
        logic [5:0]  quality;
    } t_node;

endpackage

@@ rtl/lnff_rx_if.sv @@
// lnff_rx_if: byte stream channel from the scanner link
interface lnff_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/lnff_node_if.sv @@
// lnff_node_if: decoded node result channel
interface lnff_node_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_index;
    logic [14:0] angle_x64;
    logic [15:0] range_x4;
    logic [5:0]  quality;

    modport source (output valid, output sample_index, output angle_x64,
                    output range_x4, output quality, input ready);
    modport sink (input valid, input sample_index, input angle_x64,
                  input range_x4, input quality, output ready);
endinterface

@@ rtl/lidar_node_framer_filter_core.sv @@
// lidar_node_framer_filter_core: top level of the scanner node framer and filter
//
//   channel   direction  payload                                         notes
//   i_rx      in         rx_byte[7:0]                                    one byte per transfer
//   o_node    out        sample_index, angle_x64, range_x4, quality      zero or one per byte
//   apb       in/out     paddr[3:0], pwdata/prdata[31:0]                 pready tied high
//
// one byte per cycle; its node, if any, is on o_node the cycle after the transfer
// the rate is set by the single result register behind the window decode
// i_rx stalls only while a result waits and o_node.ready is low
// synchronous active-low reset clears the window, counters and result valid
module lidar_node_framer_filter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lnff_rx_if.sink                        i_rx,
    lnff_node_if.source                    o_node,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lnff_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lnff_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lnff_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lnff_pkg::*;

    t_cfg  w_cfg;
    t_node w_node;
    logic  w_emit;
    logic  w_free;
    logic  w_accept;

    assign i_rx.ready = w_free;
    assign w_accept   = i_rx.valid && w_free;

    lnff_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lnff_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx.rx_byte),
        .i_cfg     (w_cfg),
        .o_emit    (w_emit),
        .o_node    (w_node)
    );

    lnff_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_emit  (w_emit),
        .i_node  (w_node),
        .o_free  (w_free),
        .o_node  (o_node)
    );

`ifndef SYNTHESIS
    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_node.valid && !o_node.ready) |-> !i_rx.ready)
        else $error("byte taken while a result is stalled");

    a_dist_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_node.valid |-> (o_node.range_x4 != 16'd0))
        else $error("node with zero distance");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_node.valid |-> (o_node.angle_x64 < 15'd23040))
        else $error("node angle out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_node.valid)
        else $error("result valid after reset");
`endif

endmodule

@@ rtl/lnff_apb_regs.sv @@
// lnff_apb_regs: apb configuration registers of the node framer filter
module lnff_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lnff_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lnff_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lnff_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output lnff_pkg::t_cfg                 o_cfg
);
    import lnff_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decimate_interval <= RST_DECIMATE_INTERVAL;
            r_cfg.min_distance_mm   <= RST_MIN_DISTANCE_MM;
            r_cfg.max_distance_mm   <= RST_MAX_DISTANCE_MM;
            r_cfg.min_quality       <= RST_MIN_QUALITY;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DECIMATE_INTERVAL: r_cfg.decimate_interval <= pwdata[7:0];
                REG_MIN_DISTANCE_MM:   r_cfg.min_distance_mm   <= pwdata[13:0];
                REG_MAX_DISTANCE_MM:   r_cfg.max_distance_mm   <= pwdata[13:0];
                REG_MIN_QUALITY:       r_cfg.min_quality       <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_DECIMATE_INTERVAL: prdata = {24'd0, r_cfg.decimate_interval};
            REG_MIN_DISTANCE_MM:   prdata = {18'd0, r_cfg.min_distance_mm};
            REG_MAX_DISTANCE_MM:   prdata = {18'd0, r_cfg.max_distance_mm};
            REG_MIN_QUALITY:       prdata = {26'd0, r_cfg.min_quality};
            default:               prdata = '0;
        endcase
    end

endmodule

@@ rtl/lnff_framer.sv @@
// lnff_framer: byte window, node counters, decode and limit checks
module lnff_framer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_rx_byte,
    input  lnff_pkg::t_cfg i_cfg,
    output logic           o_emit,
    output lnff_pkg::t_node o_node
);
    import lnff_pkg::*;

    logic [7:0]  r_win [NODE_BYTES];
    logic [31:0] r_valid_count;
    logic [7:0]  r_decimate_count;

    logic [7:0]  w_b0, w_b1, w_b2, w_b3, w_b4;
    logic        w_node_ok;
    logic [7:0]  w_dc_inc;
    logic        w_attempt;
    logic [13:0] w_dist_mm;
    logic        w_pass;
    logic [31:0] n_valid_count;
    logic [7:0]  n_decimate_count;

    // window as it stands after the incoming byte
    assign w_b0 = r_win[1];
    assign w_b1 = r_win[2];
    assign w_b2 = r_win[3];
    assign w_b3 = r_win[4];
    assign w_b4 = i_rx_byte;

    assign w_node_ok = (w_b0[0] != w_b0[1]) && w_b1[0];
    assign w_dc_inc  = r_decimate_count + 8'd1;
    assign w_attempt = w_dc_inc >= i_cfg.decimate_interval;

    assign o_node.sample_index = r_valid_count + 32'd1;
    assign o_node.angle_x64    = {w_b2, w_b1[7:1]};
    assign o_node.range_x4     = {w_b4, w_b3};
    assign o_node.quality      = w_b0[7:2];
    assign w_dist_mm           = o_node.range_x4[15:2];

    assign w_pass = (o_node.range_x4 != 16'd0)
                 && (o_node.angle_x64[14:6] < 9'(ANGLE_DEG_LIMIT))
                 && (w_dist_mm >= i_cfg.min_distance_mm)
                 && (w_dist_mm <= i_cfg.max_distance_mm)
                 && (o_node.quality >= i_cfg.min_quality);

    assign o_emit = w_node_ok && w_attempt && w_pass;

    always_comb begin
        n_valid_count    = r_valid_count;
        n_decimate_count = r_decimate_count;
        if (w_node_ok) begin
            n_valid_count    = o_node.sample_index;
            n_decimate_count = w_attempt ? 8'd0 : w_dc_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODE_BYTES; i++) begin
                r_win[i] <= 8'd0;
            end
            r_valid_count    <= 32'd0;
            r_decimate_count <= 8'd0;
        end else if (i_accept) begin
            for (int i = 0; i < NODE_BYTES - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[NODE_BYTES-1] <= i_rx_byte;
            r_valid_count       <= n_valid_count;
            r_decimate_count    <= n_decimate_count;
        end
    end

endmodule

@@ rtl/lnff_out_reg.sv @@
// lnff_out_reg: result register between the framer and the node channel
module lnff_out_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_emit,
    input  lnff_pkg::t_node i_node,
    output logic            o_free,
    lnff_node_if.source     o_node
);
    import lnff_pkg::*;

    logic  r_valid;
    t_node r_node;

    assign o_free = !r_valid || o_node.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_emit;
        end else if (o_node.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_emit) begin
            r_node <= i_node;
        end
    end

    assign o_node.valid        = r_valid;
    assign o_node.sample_index = r_node.sample_index;
    assign o_node.angle_x64    = r_node.angle_x64;
    assign o_node.range_x4     = r_node.range_x4;
    assign o_node.quality      = r_node.quality;

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for the scanner node framer and filter core
`timescale 1ns / 100ps

module testbench;
    import lnff_pkg::*;

    typedef enum logic [1:0] {
        NODE_FROM_MODEL,
        NODE_NONE,
        NODE_TYPED
    } t_node_check;

    typedef struct {
        logic [7:0]  rx_byte;
        t_node_check check;
        t_node       node;
    } t_dir_row;

    localparam int PHASES = 9;
    localparam int PHASE_BYTES = 170;
    localparam int LONG_HOLD = 300;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    lnff_rx_if   rx_if ();
    lnff_node_if node_if ();

    lidar_node_framer_filter_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_node  (node_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // framer state mirrored on the bench side
    logic [7:0]  rx_window [NODE_BYTES];
    logic [31:0] node_total = '0;
    logic [7:0]  decim_count = '0;
    t_cfg        model_cfg;

    t_node       pending_nodes [$];
    int          mismatch_count = 0;

    t_node_check row_check = NODE_FROM_MODEL;
    t_node       row_node = '0;

    bit src_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;
    int hold_requests = 0;
    int hold_served = 0;
    int stall_left = 0;

    // after reset the interval is set to 1 and the limits wide open
    t_dir_row directed [25] = '{
        '{8'hFD, NODE_NONE, '0},
        '{8'h01, NODE_NONE, '0},
        '{8'h00, NODE_NONE, '0},
        '{8'h04, NODE_NONE, '0},
        '{8'h00, NODE_TYPED, '{32'd1, 15'd0, 16'd4, 6'd63}},
        // largest legal angle, largest distance, zero quality
        '{8'h01, NODE_NONE, '0},
        '{8'hFF, NODE_NONE, '0},
        '{8'hB3, NODE_NONE, '0},
        '{8'hFF, NODE_NONE, '0},
        '{8'hFF, NODE_TYPED, '{32'd2, 15'd23039, 16'd65535, 6'd0}},
        // angle of exactly 360 degrees is dropped
        '{8'h02, NODE_NONE, '0},
        '{8'h01, NODE_NONE, '0},
        '{8'hB4, NODE_NONE, '0},
        '{8'h04, NODE_NONE, '0},
        '{8'h00, NODE_NONE, '0},
        // zero distance is dropped
        '{8'h06, NODE_NONE, '0},
        '{8'h03, NODE_NONE, '0},
        '{8'h00, NODE_NONE, '0},
        '{8'h00, NODE_NONE, '0},
        '{8'h00, NODE_NONE, '0},
        // distance below one mm truncates to zero mm
        '{8'h05, NODE_NONE, '0},
        '{8'h01, NODE_NONE, '0},
        '{8'h00, NODE_NONE, '0},
        '{8'h03, NODE_NONE, '0},
        '{8'h00, NODE_TYPED, '{32'd5, 15'd0, 16'd3, 6'd1}}
    };

    function automatic t_cfg cfg_of(int interval, int dmin, int dmax, int qmin);
        t_cfg c;
        c.decimate_interval = 8'(interval);
        c.min_distance_mm = 14'(dmin);
        c.max_distance_mm = 14'(dmax);
        c.min_quality = 6'(qmin);
        return c;
    endfunction

    function automatic bit frame_rx_byte(input logic [7:0] rx, output t_node node);
        logic [15:0] range_raw;
        logic [14:0] ang;
        node = '0;
        for (int i = 0; i < NODE_BYTES - 1; i++) begin
            rx_window[i] = rx_window[i + 1];
        end
        rx_window[NODE_BYTES - 1] = rx;
        if (rx_window[0][0] == rx_window[0][1] || !rx_window[1][0]) begin
            return 1'b0;
        end
        node_total = node_total + 32'd1;
        decim_count = decim_count + 8'd1;
        if (decim_count < model_cfg.decimate_interval) begin
            return 1'b0;
        end
        decim_count = '0;
        ang = {rx_window[2], rx_window[1][7:1]};
        range_raw = {rx_window[4], rx_window[3]};
        if (range_raw == 16'd0 || int'(ang[14:6]) >= ANGLE_DEG_LIMIT) begin
            return 1'b0;
        end
        if (range_raw[15:2] < model_cfg.min_distance_mm ||
            range_raw[15:2] > model_cfg.max_distance_mm) begin
            return 1'b0;
        end
        if (rx_window[0][7:2] < model_cfg.min_quality) begin
            return 1'b0;
        end
        node.sample_index = node_total;
        node.angle_x64 = ang;
        node.range_x4 = range_raw;
        node.quality = rx_window[0][7:2];
        return 1'b1;
    endfunction

    // a setup phase then an access phase, starting and ending at a falling edge
    task automatic apb_transfer(input t_reg_idx idx, input bit wr, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        if (wr) begin
            unique case (idx)
                REG_DECIMATE_INTERVAL: model_cfg.decimate_interval = wdata[7:0];
                REG_MIN_DISTANCE_MM:   model_cfg.min_distance_mm = wdata[13:0];
                REG_MAX_DISTANCE_MM:   model_cfg.max_distance_mm = wdata[13:0];
                REG_MIN_QUALITY:       model_cfg.min_quality = wdata[5:0];
                default: ;
            endcase
        end
        @(negedge clk);
    endtask

    task automatic check_reset_reg(input t_reg_idx idx, input logic [31:0] want);
        logic [31:0] got;
        apb_transfer(idx, 1'b0, '0, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", idx.name(), want, got);
            mismatch_count++;
        end
    endtask

    task automatic write_config(input t_cfg c);
        logic [31:0] unused;
        apb_transfer(REG_DECIMATE_INTERVAL, 1'b1, 32'(c.decimate_interval), unused);
        apb_transfer(REG_MIN_DISTANCE_MM, 1'b1, 32'(c.min_distance_mm), unused);
        apb_transfer(REG_MAX_DISTANCE_MM, 1'b1, 32'(c.max_distance_mm), unused);
        apb_transfer(REG_MIN_QUALITY, 1'b1, 32'(c.min_quality), unused);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input t_node_check check, input t_node node);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        row_check <= check;
        row_node <= node;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // mostly whole nodes with random content, some cut short, some line noise
    task automatic send_random_burst(inout int sent);
        int          pick;
        int          cut;
        int          lo;
        int          hi;
        logic [1:0]  start;
        logic [14:0] ang;
        logic [15:0] range_raw;
        logic [7:0]  fb [NODE_BYTES];
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            cut = $urandom_range(1, 6);
            repeat (cut) send_byte(8'($urandom), NODE_FROM_MODEL, '0);
            sent += cut;
        end else begin
            start = $urandom_range(0, 1) ? 2'b01 : 2'b10;
            ang = ($urandom_range(0, 4) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23039));
            lo = int'(model_cfg.min_distance_mm) * 4;
            hi = int'(model_cfg.max_distance_mm) * 4 + 3;
            case ($urandom_range(0, 4))
                0: range_raw = 16'($urandom);
                1: range_raw = 16'($urandom_range(0, 3));
                2: range_raw = 16'($urandom_range(0, 1) ? lo + $urandom_range(0, 1) - 1
                                                       : hi + $urandom_range(0, 1));
                default: range_raw = (lo > hi) ? 16'($urandom) : 16'($urandom_range(lo, hi));
            endcase
            fb[0] = {6'($urandom_range(0, 63)), start};
            fb[1] = {ang[6:0], 1'b1};
            fb[2] = ang[14:7];
            fb[3] = range_raw[7:0];
            fb[4] = range_raw[15:8];
            cut = (pick == 2) ? $urandom_range(1, NODE_BYTES - 1) : NODE_BYTES;
            for (int i = 0; i < cut; i++) begin
                send_byte(fb[i], NODE_FROM_MODEL, '0);
            end
            sent += cut;
        end
    endtask

    task automatic drain_nodes();
        int waited;
        waited = 0;
        while (pending_nodes.size() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            node_if.ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            stall_left <= LONG_HOLD;
            node_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            node_if.ready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 12);
            node_if.ready <= 1'b0;
        end else begin
            node_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : node_scoreboard
        t_node modeled;
        t_node want;
        bit    fires;
        if (rst_n) begin
            if (rx_if.valid && rx_if.ready) begin
                fires = frame_rx_byte(rx_if.rx_byte, modeled);
                if (row_check == NODE_TYPED) begin
                    pending_nodes.push_back(row_node);
                end else if (row_check == NODE_FROM_MODEL && fires) begin
                    pending_nodes.push_back(modeled);
                end
            end
            if (node_if.valid && node_if.ready) begin
                if (pending_nodes.size() == 0) begin
                    $error("unexpected node transfer, sample_index %0d", node_if.sample_index);
                    mismatch_count++;
                end else begin
                    want = pending_nodes.pop_front();
                    if (node_if.sample_index !== want.sample_index) begin
                        $error("sample_index: expected %0d, got %0d",
                               want.sample_index, node_if.sample_index);
                        mismatch_count++;
                    end
                    if (node_if.angle_x64 !== want.angle_x64) begin
                        $error("angle_x64: expected %0d, got %0d",
                               want.angle_x64, node_if.angle_x64);
                        mismatch_count++;
                    end
                    if (node_if.range_x4 !== want.range_x4) begin
                        $error("range_x4: expected %0d, got %0d",
                               want.range_x4, node_if.range_x4);
                        mismatch_count++;
                    end
                    if (node_if.quality !== want.quality) begin
                        $error("quality: expected %0d, got %0d", want.quality, node_if.quality);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_cfg plan [PHASES];
        int   sent;
        rst_n = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        model_cfg = cfg_of(RST_DECIMATE_INTERVAL, RST_MIN_DISTANCE_MM,
                           RST_MAX_DISTANCE_MM, RST_MIN_QUALITY);
        for (int i = 0; i < NODE_BYTES; i++) begin
            rx_window[i] = '0;
        end

        plan[0] = cfg_of(20, 100, 6000, 10);
        plan[1] = cfg_of(1, 0, 16383, 0);
        plan[2] = cfg_of(255, 0, 16383, 0);
        plan[3] = cfg_of(0, 0, 16383, 0);
        plan[4] = cfg_of(200, 50, 9000, 5);
        plan[5] = cfg_of(2, 100, 6000, 10);
        plan[6] = cfg_of(3, 16383, 0, 0);
        plan[7] = cfg_of(1, 100, 6000, 63);
        plan[8] = cfg_of($urandom_range(1, 4), $urandom_range(0, 2000),
                         $urandom_range(3000, 16383), $urandom_range(0, 40));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        check_reset_reg(REG_DECIMATE_INTERVAL, 32'(RST_DECIMATE_INTERVAL));
        check_reset_reg(REG_MIN_DISTANCE_MM, 32'(RST_MIN_DISTANCE_MM));
        check_reset_reg(REG_MAX_DISTANCE_MM, 32'(RST_MAX_DISTANCE_MM));
        check_reset_reg(REG_MIN_QUALITY, 32'(RST_MIN_QUALITY));

        write_config(cfg_of(1, 0, 16383, 0));
        foreach (directed[i]) begin
            send_byte(directed[i].rx_byte, directed[i].check, directed[i].node);
        end
        rx_if.valid <= 1'b0;
        drain_nodes();

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1) begin
                src_idle_on = 1'b0;
                sink_idle_on = 1'b0;
            end
            write_config(plan[p]);
            // receiver holds off while bytes keep coming
            if (p == 1) begin
                hold_requests++;
            end
            sent = 0;
            while (sent < PHASE_BYTES) send_random_burst(sent);
            rx_if.valid <= 1'b0;
            drain_nodes();
        end

        if (pending_nodes.size() != 0) begin
            $error("%0d expected nodes never arrived", pending_nodes.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lnff_pkg.sv
rtl/lnff_rx_if.sv
rtl/lnff_node_if.sv
rtl/lnff_apb_regs.sv
rtl/lnff_framer.sv
rtl/lnff_out_reg.sv
rtl/lidar_node_framer_filter_core.sv
tb/testbench.sv
